[src/u2j_pkg.sv]
// Package for the UTF-8 to JSON escaper: result descriptor kinds, character
// constants and the hex digit function. No dependencies.
package u2j_pkg;

  // What follows the leading '?' characters of one request's results.
  typedef enum logic [2:0] {
    TAIL_NONE = 3'd0,  // only '?' characters, or nothing at all
    TAIL_CHAR = 3'd1,  // one character taken as it is
    TAIL_ESC  = 3'd2,  // backslash and one escape letter
    TAIL_HEX  = 3'd3,  // one backslash-u escape
    TAIL_PAIR = 3'd4   // two backslash-u escapes (surrogate pair)
  } tail_kind_t;

  localparam logic [6:0] CH_QUOTE     = 7'h22;
  localparam logic [6:0] CH_BACKSLASH = 7'h5C;
  localparam logic [6:0] CH_NEWLINE   = 7'h0A;
  localparam logic [6:0] CH_RETURN    = 7'h0D;
  localparam logic [6:0] CH_TAB       = 7'h09;
  localparam logic [6:0] CH_QMARK     = 7'h3F;
  localparam logic [6:0] CH_LOWER_U   = 7'h75;
  localparam logic [6:0] CH_LOWER_N   = 7'h6E;
  localparam logic [6:0] CH_LOWER_R   = 7'h72;
  localparam logic [6:0] CH_LOWER_T   = 7'h74;

  localparam logic [15:0] HIGH_SURROGATE = 16'hD800;
  localparam logic [15:0] LOW_SURROGATE  = 16'hDC00;
  localparam logic [20:0] PLANE_OFFSET   = 21'h10000;

  // Uppercase hex digit for one nibble.
  function automatic logic [6:0] hex_digit(input logic [3:0] nib);
    logic [6:0] ch;
    if (nib < 4'd10) begin
      ch = 7'h30 + {3'd0, nib};
    end else begin
      ch = 7'h37 + {3'd0, nib};
    end
    return ch;
  endfunction

endpackage

[src/utf8_to_json_unicode_escaper.sv]
// Top level of the UTF-8 to JSON string escaper with UTF-16 escapes.
// Depends on u2j_pkg for descriptor kinds, character codes and hex digits.
//
//   channel  dir  tdata                    tlast         tuser
//   s_*      in   [7:0] text_byte          end_of_text   -
//   m_*      out  [6:0] out_char, [7] zero last_of_run   text_done
//
// Each accepted request is decoded in the cycle it is taken and stored as a
// compact descriptor: a count of leading '?' characters and a tail (plain
// character, two-character escape, one or two backslash-u escapes). The
// characters are then sent one per cycle while m_tready is high; a request
// produces n characters (n from 0 to 12). A new request is taken in the
// same cycle that the last character of the previous one is taken, so
// single-character requests stream at one per cycle while m_tready is high. A
// continuation byte that produces nothing is absorbed without output. Reset
// (rst, synchronous) closes any open sequence and empties the output register.
module utf8_to_json_unicode_escaper (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,   // end_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
  output logic       m_tlast,   // last_of_run
  output logic       m_tuser    // [0] text_done
);
  import u2j_pkg::*;

  // Decoder state, carried between requests.
  logic [20:0] code_accum;
  logic [1:0]  bytes_expected;
  logic [1:0]  bytes_taken;

  // Output descriptor register.
  logic        buf_valid;
  logic [3:0]  char_count;
  logic [3:0]  char_idx;
  logic [1:0]  q_count;
  tail_kind_t  tail_kind;
  logic [15:0] word0;
  logic [15:0] word1;
  logic        buf_end;

  logic [20:0] code_accum_next;
  logic [1:0]  bytes_expected_next;
  logic [1:0]  bytes_taken_next;
  logic [1:0]  q_count_next;
  tail_kind_t  tail_kind_next;
  logic [15:0] word0_next;
  logic [15:0] word1_next;
  logic [3:0]  char_count_next;

  logic [7:0]  c;
  logic        is_cont;
  logic        fresh;
  logic [20:0] cont_accum;
  logic [1:0]  cont_taken;
  logic [20:0] cp_off;
  logic        last_char;
  logic        s_accept;
  logic        m_accept;

  assign c          = s_tdata;
  assign is_cont    = (c[7:6] == 2'b10);
  assign cont_accum = {code_accum[14:0], c[5:0]};
  assign cont_taken = bytes_taken + 2'd1;
  assign cp_off     = cont_accum - PLANE_OFFSET;

  // Decode one request into the next decoder state and a descriptor.
  always_comb begin
    code_accum_next     = code_accum;
    bytes_expected_next = bytes_expected;
    bytes_taken_next    = bytes_taken;
    q_count_next        = 2'd0;
    tail_kind_next      = TAIL_NONE;
    word0_next          = 16'd0;
    word1_next          = 16'd0;
    fresh               = 1'b0;

    if (bytes_expected != 2'd0) begin
      if (is_cont) begin
        code_accum_next  = cont_accum;
        bytes_taken_next = cont_taken;
        if (cont_taken >= bytes_expected) begin
          // Sequence complete: emit the code point.
          code_accum_next     = 21'd0;
          bytes_expected_next = 2'd0;
          bytes_taken_next    = 2'd0;
          if (cont_accum[20:16] == 5'd0) begin
            tail_kind_next = TAIL_HEX;
            word0_next     = cont_accum[15:0];
          end else begin
            tail_kind_next = TAIL_PAIR;
            word0_next     = HIGH_SURROGATE + {5'd0, cp_off[20:10]};
            word1_next     = LOW_SURROGATE | {6'd0, cp_off[9:0]};
          end
        end else if (s_tlast) begin
          // Text ends inside the sequence: one '?' per byte taken.
          q_count_next        = cont_taken + 2'd1;
          code_accum_next     = 21'd0;
          bytes_expected_next = 2'd0;
          bytes_taken_next    = 2'd0;
        end
      end else begin
        // Broken sequence: '?' for the lead and each continuation, then the
        // breaking byte is decoded as a new one.
        q_count_next        = bytes_taken + 2'd1;
        code_accum_next     = 21'd0;
        bytes_expected_next = 2'd0;
        bytes_taken_next    = 2'd0;
        fresh               = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end

    if (fresh) begin
      if (c[7] == 1'b0) begin
        unique case (c[6:0])
          CH_QUOTE, CH_BACKSLASH: begin
            tail_kind_next   = TAIL_ESC;
            word0_next[6:0]  = c[6:0];
          end
          CH_NEWLINE: begin
            tail_kind_next   = TAIL_ESC;
            word0_next[6:0]  = CH_LOWER_N;
          end
          CH_RETURN: begin
            tail_kind_next   = TAIL_ESC;
            word0_next[6:0]  = CH_LOWER_R;
          end
          CH_TAB: begin
            tail_kind_next   = TAIL_ESC;
            word0_next[6:0]  = CH_LOWER_T;
          end
          default: begin
            if (c[6:5] == 2'b00) begin
              tail_kind_next = TAIL_HEX;
              word0_next     = {8'd0, c};
            end else begin
              tail_kind_next  = TAIL_CHAR;
              word0_next[6:0] = c[6:0];
            end
          end
        endcase
      end else if ((c[7:6] == 2'b10) || (c[7:3] == 5'b11111)) begin
        // Bad lead byte.
        tail_kind_next  = TAIL_CHAR;
        word0_next[6:0] = CH_QMARK;
      end else if (s_tlast) begin
        // Lead byte at the end of the text cannot be completed.
        tail_kind_next  = TAIL_CHAR;
        word0_next[6:0] = CH_QMARK;
      end else begin
        bytes_taken_next = 2'd0;
        priority if (c[7:5] == 3'b110) begin
          code_accum_next     = {16'd0, c[4:0]};
          bytes_expected_next = 2'd1;
        end else if (c[7:4] == 4'b1110) begin
          code_accum_next     = {17'd0, c[3:0]};
          bytes_expected_next = 2'd2;
        end else begin
          code_accum_next     = {18'd0, c[2:0]};
          bytes_expected_next = 2'd3;
        end
      end
    end
  end

  // Number of characters the descriptor will produce.
  always_comb begin
    logic [3:0] tail_len;
    unique case (tail_kind_next)
      TAIL_NONE: tail_len = 4'd0;
      TAIL_CHAR: tail_len = 4'd1;
      TAIL_ESC:  tail_len = 4'd2;
      TAIL_HEX:  tail_len = 4'd6;
      TAIL_PAIR: tail_len = 4'd12;
      default:   tail_len = 4'd0;
    endcase
    char_count_next = {2'd0, q_count_next} + tail_len;
  end

  assign last_char = (char_idx == (char_count - 4'd1));
  assign s_tready  = !buf_valid || (m_tready && last_char);
  assign s_accept  = s_tvalid && s_tready;
  assign m_accept  = buf_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_accum     <= 21'd0;
      bytes_expected <= 2'd0;
      bytes_taken    <= 2'd0;
      buf_valid      <= 1'b0;
      char_idx       <= 4'd0;
      char_count     <= 4'd0;
    end else begin
      if (s_accept) begin
        code_accum     <= code_accum_next;
        bytes_expected <= bytes_expected_next;
        bytes_taken    <= bytes_taken_next;
        buf_valid      <= (char_count_next != 4'd0);
        char_idx       <= 4'd0;
        char_count     <= char_count_next;
      end else if (m_accept) begin
        if (last_char) begin
          buf_valid <= 1'b0;
        end
        char_idx <= char_idx + 4'd1;
      end
    end
  end

  // Descriptor payload needs no reset.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      q_count   <= q_count_next;
      tail_kind <= tail_kind_next;
      word0     <= word0_next;
      word1     <= word1_next;
      buf_end   <= s_tlast;
    end
  end

  // Pick the character at the current index from the descriptor.
  always_comb begin
    logic [3:0]  t;
    logic [3:0]  sub;
    logic [15:0] word;
    logic [6:0]  ch;
    t    = char_idx - {2'd0, q_count};
    sub  = (t >= 4'd6) ? (t - 4'd6) : t;
    word = (t >= 4'd6) ? word1 : word0;
    if (char_idx < {2'd0, q_count}) begin
      ch = CH_QMARK;
    end else begin
      unique case (tail_kind)
        TAIL_CHAR: ch = word0[6:0];
        TAIL_ESC:  ch = (t == 4'd0) ? CH_BACKSLASH : word0[6:0];
        TAIL_HEX, TAIL_PAIR: begin
          unique case (sub)
            4'd0:    ch = CH_BACKSLASH;
            4'd1:    ch = CH_LOWER_U;
            4'd2:    ch = hex_digit(word[15:12]);
            4'd3:    ch = hex_digit(word[11:8]);
            4'd4:    ch = hex_digit(word[7:4]);
            default: ch = hex_digit(word[3:0]);
          endcase
        end
        default:   ch = CH_QMARK;
      endcase
    end
    m_tdata = {1'b0, ch};
  end

  assign m_tvalid = buf_valid;
  assign m_tlast  = last_char;
  assign m_tuser  = last_char && buf_end;

endmodule
